>>> sv/arsb_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the per-channel blend function of the stamp blend unit.
// No dependencies.
package arsb_pkg;

	localparam int PIX_W      = 32;
	localparam int CNT_W      = 19;
	localparam int COORD_W    = 15;  // signed, holds a 13-bit position plus or minus the radius
	localparam int POS_W      = 13;
	localparam int RAD_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int CHAN_W     = 8;
	localparam int OPA_W      = 9;
	localparam logic [OPA_W-1:0]  OPA_FULL = 9'd256;
	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

	typedef enum logic [1:0] {
		OP_STAMP = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAINT_RED   = 3'd0,
		REG_PAINT_GREEN = 3'd1,
		REG_PAINT_BLUE  = 3'd2,
		REG_PAINT_ALPHA = 3'd3,
		REG_OPACITY     = 3'd4,
		REG_RADIUS      = 3'd5,
		REG_CANVAS_W    = 3'd6,
		REG_CANVAS_H    = 3'd7
	} cfg_reg_t;

	// Memory command from the sequencer to the pixel path.
	typedef struct packed {
		logic rd;     // read the entry at the address
		logic wr;     // store the write data at the address
		logic blend;  // write the blended read data back in the following cycle
	} mem_cmd_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             off;
		logic [CNT_W-1:0] count;
	} result_t;

	// floor(c*op/256) + floor(p*(256-op)/256), op already saturated to 256
	function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] c,
		input logic [CHAN_W-1:0] p, input logic [OPA_W-1:0] op);
		logic [16:0] prod_c;
		logic [16:0] prod_p;
		logic [9:0]  sum;
		prod_c = c * op;
		prod_p = p * (OPA_FULL - op);
		sum    = {1'b0, prod_c[16:8]} + {1'b0, prod_p[16:8]};
		return (sum > {2'b00, CHAN_MAX}) ? CHAN_MAX : sum[CHAN_W-1:0];
	endfunction

endpackage

>>> sv/arsb_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file with saturation of the stored settings to usable values.
// Depends on arsb_pkg.
module arsb_cfg_regs import arsb_pkg::*; #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int MAX_RADIUS = 255,
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [PIX_W-1:0]      paint,
	output logic [OPA_W-1:0]      opacity,
	output logic [RAD_W-1:0]      radius,
	output logic [WW-1:0]         width,
	output logic [HW-1:0]         height
);

	logic [CHAN_W-1:0]     red_q, green_q, blue_q, alpha_q;
	logic [OPA_W-1:0]      opa_q;
	logic [RAD_W-1:0]      rad_q;
	logic [CFG_DATA_W-1:0] cw_q, ch_q;
	logic [13:0]           cw_ext, ch_ext;
	logic [13:0]           w_sat, h_sat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
			alpha_q <= CHAN_MAX;
			opa_q   <= OPA_FULL;
			rad_q   <= 8'd1;
			cw_q    <= 10'd512;
			ch_q    <= 10'd512;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_PAINT_RED:   red_q   <= cfg_data[CHAN_W-1:0];
				REG_PAINT_GREEN: green_q <= cfg_data[CHAN_W-1:0];
				REG_PAINT_BLUE:  blue_q  <= cfg_data[CHAN_W-1:0];
				REG_PAINT_ALPHA: alpha_q <= cfg_data[CHAN_W-1:0];
				REG_OPACITY:     opa_q   <= cfg_data[OPA_W-1:0];
				REG_RADIUS:      rad_q   <= cfg_data[RAD_W-1:0];
				REG_CANVAS_W:    cw_q    <= cfg_data;
				REG_CANVAS_H:    ch_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign paint   = {alpha_q, blue_q, green_q, red_q};
	assign opacity = (opa_q > OPA_FULL) ? OPA_FULL : opa_q;
	assign radius  = ({5'd0, rad_q} > 13'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : rad_q;

	// zero counts as one, oversize clamps to the store geometry
	assign cw_ext = {4'd0, cw_q};
	assign ch_ext = {4'd0, ch_q};
	assign w_sat  = (cw_ext == '0) ? 14'd1 : (cw_ext > 14'(MAX_WIDTH))  ? 14'(MAX_WIDTH)  : cw_ext;
	assign h_sat  = (ch_ext == '0) ? 14'd1 : (ch_ext > 14'(MAX_HEIGHT)) ? 14'(MAX_HEIGHT) : ch_ext;
	assign width  = w_sat[WW-1:0];
	assign height = h_sat[HW-1:0];

endmodule

>>> sv/arsb_pixel_path.sv
`timescale 1ns / 1ps
// Frame store (one write, one registered read port) and the read-modify-write blend stage.
// Depends on arsb_pkg.
module arsb_pixel_path import arsb_pkg::*; #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mem_cmd_t         cmd,
	input  logic [AW-1:0]    addr,
	input  logic [PIX_W-1:0] wdata,
	input  logic [PIX_W-1:0] paint,
	input  logic [OPA_W-1:0] opacity,
	output logic [PIX_W-1:0] rdata
);

	logic [PIX_W-1:0] frame_mem_q [DEPTH];
	logic [PIX_W-1:0] rdata_s1;
	logic [AW-1:0]    addr_s1;
	logic             blend_s1;
	logic [PIX_W-1:0] blended;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [PIX_W-1:0] wdat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_s1 <= 1'b0;
		end else begin
			blend_s1 <= cmd.blend;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr;
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			blended[k*CHAN_W +: CHAN_W] = blend_chan(paint[k*CHAN_W +: CHAN_W],
				rdata_s1[k*CHAN_W +: CHAN_W], opacity);
		end
	end

	// direct writes and blend write-backs never fall in the same cycle
	assign we    = cmd.wr | blend_s1;
	assign waddr = cmd.wr ? addr : addr_s1;
	assign wdat  = cmd.wr ? wdata : blended;

	always_ff @(posedge clk) begin
		if (we) begin
			frame_mem_q[waddr] <= wdat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_s1 <= frame_mem_q[addr];
		end
	end

	assign rdata = rdata_s1;

endmodule

>>> sv/arsb_walker.sv
`timescale 1ns / 1ps
// Item sequencer: clips the stamp square, forms addresses and walks the rectangle.
// Depends on arsb_pkg.
module arsb_walker import arsb_pkg::*; #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	localparam int WW    = $clog2(MAX_WIDTH + 1),
	localparam int HW    = $clog2(MAX_HEIGHT + 1),
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       opcode,
	input  logic [POS_W-1:0] pos_x,
	input  logic [POS_W-1:0] pos_y,
	input  logic [PIX_W-1:0] write_pixel,
	input  logic [RAD_W-1:0] radius,
	input  logic [WW-1:0]    width,
	input  logic [HW-1:0]    height,
	output mem_cmd_t         mem_cmd,
	output logic [AW-1:0]    mem_addr,
	output logic [PIX_W-1:0] mem_wdata,
	input  logic [PIX_W-1:0] mem_rdata,
	output logic             res_valid,
	input  logic             res_take,
	output result_t          res
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CLIP  = 6'b000010,
		ST_BASE  = 6'b000100,
		ST_WALK  = 6'b001000,
		ST_DRAIN = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t            state_q;
	opcode_t           op_q;
	logic [POS_W-1:0]  x_q, y_q;
	logic [RAD_W-1:0]  rad_q;
	logic [PIX_W-1:0]  wpix_q;
	logic [WW-1:0]     col_lo_q, col_hi_q, col_q;
	logic [HW-1:0]     row_lo_q, row_hi_q, row_q;
	logic [AW-1:0]     addr_q, row_base_q;
	logic [PIX_W-1:0]  pix_q;
	logic              off_q;
	logic [CNT_W-1:0]  cnt_q;

	logic signed [COORD_W-1:0] sx, ex, sy, ey, rext, wext, hext;
	logic                      off_now;
	logic [HW+WW-1:0]          base_full;
	logic [AW-1:0]             w_addr, next_base;
	logic                      last_px;

	assign rext = signed'({{(COORD_W-RAD_W){1'b0}}, rad_q});
	assign wext = signed'({{(COORD_W-WW){1'b0}}, width});
	assign hext = signed'({{(COORD_W-HW){1'b0}}, height});
	assign sx   = signed'({{(COORD_W-POS_W){x_q[POS_W-1]}}, x_q}) - rext;
	assign ex   = signed'({{(COORD_W-POS_W){x_q[POS_W-1]}}, x_q}) + rext;
	assign sy   = signed'({{(COORD_W-POS_W){y_q[POS_W-1]}}, y_q}) - rext;
	assign ey   = signed'({{(COORD_W-POS_W){y_q[POS_W-1]}}, y_q}) + rext;
	assign off_now = (ex < 0) || (ey < 0) || (sx >= wext) || (sy >= hext);

	assign base_full = row_lo_q * width + {{HW{1'b0}}, col_lo_q};
	assign w_addr    = AW'(width);
	assign next_base = row_base_q + w_addr;
	assign last_px   = (col_q == col_hi_q) && (row_q == row_hi_q);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q    <= pos_x;
				y_q    <= pos_y;
				wpix_q <= write_pixel;
				rad_q  <= (opcode_t'(opcode) == OP_STAMP) ? radius : '0;
			end
			ST_CLIP: begin
				col_lo_q <= (sx < 0) ? '0 : sx[WW-1:0];
				col_hi_q <= (ex >= wext) ? width - 1'b1 : ex[WW-1:0];
				row_lo_q <= (sy < 0) ? '0 : sy[HW-1:0];
				row_hi_q <= (ey >= hext) ? height - 1'b1 : ey[HW-1:0];
			end
			ST_BASE: begin
				addr_q     <= base_full[AW-1:0];
				row_base_q <= base_full[AW-1:0];
				col_q      <= col_lo_q;
				row_q      <= row_lo_q;
			end
			ST_WALK: begin
				if (col_q == col_hi_q) begin
					col_q      <= col_lo_q;
					row_q      <= row_q + 1'b1;
					row_base_q <= next_base;
					addr_q     <= next_base;
				end else begin
					col_q  <= col_q + 1'b1;
					addr_q <= addr_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_NOP;
			off_q   <= 1'b0;
			cnt_q   <= '0;
			pix_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= opcode_t'(opcode);
						off_q   <= 1'b0;
						cnt_q   <= '0;
						pix_q   <= '0;
						state_q <= ST_CLIP;
					end
				end
				ST_CLIP: begin
					if (op_q == OP_NOP) begin
						state_q <= ST_DONE;
					end else if (off_now) begin
						off_q   <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_BASE;
					end
				end
				ST_BASE: state_q <= ST_WALK;
				ST_WALK: begin
					if (op_q != OP_READ) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (op_q != OP_STAMP || last_px) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (op_q == OP_READ) begin
						pix_q <= mem_rdata;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		mem_cmd = '0;
		if (state_q == ST_WALK) begin
			mem_cmd.rd    = (op_q == OP_STAMP) || (op_q == OP_READ);
			mem_cmd.wr    = (op_q == OP_WRITE);
			mem_cmd.blend = (op_q == OP_STAMP);
		end
	end

	assign mem_addr  = addr_q;
	assign mem_wdata = wpix_q;

	assign res_valid = (state_q == ST_DONE);
	assign res.pixel = pix_q;
	assign res.off   = off_q;
	assign res.count = cnt_q;

endmodule

>>> sv/alpha_rect_stamp_blend_unit.sv
`timescale 1ns / 1ps
// Alpha-blended square stamp engine over an RGBA frame store: top level.
// Depends on arsb_pkg, arsb_cfg_regs, arsb_walker, arsb_pixel_path.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one item per transfer: a stamp at
//   (pos_x, pos_y), a single pixel write, a single pixel read, or a no-op.
//   Output channel (out_valid/out_stall) returns exactly one result per item:
//   read_pixel, off_canvas and pixels_written.
//   Config channel (cfg_valid/cfg_ready, always ready) writes one register per
//   transfer; write it only while no item is in flight.
// Timing:
//   One item at a time. Accept, clip and address setup come first, then the
//   frame store is walked at one pixel per cycle (read in one cycle, blended
//   write-back in the next, overlapped with the following read), then a drain
//   step and a done step that hands the result to the output register.
//   A write or read walks a single pixel; an off-canvas item or a no-op skips
//   the walk and the drain. One store read and one store write per cycle
//   set the pace. Pixels of one stamp are all distinct, so the overlapped read
//   and write-back never hit the same entry; items do not overlap.
// Reset: returns control state and config registers to their defaults; the frame store holds
//   no defined content until written (no clearing pass).
// Stall: the result sits in an output register; the next item is accepted
//   meanwhile, and its result waits until the register has been taken.
module alpha_rect_stamp_blend_unit import arsb_pkg::*; #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int MAX_RADIUS = 255
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            opcode,
	input  logic [POS_W-1:0]      pos_x,
	input  logic [POS_W-1:0]      pos_y,
	input  logic [PIX_W-1:0]      write_pixel,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_W-1:0]      read_pixel,
	output logic                  off_canvas,
	output logic [CNT_W-1:0]      pixels_written,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// saturated settings
	logic [PIX_W-1:0] paint;
	logic [OPA_W-1:0] opacity;
	logic [RAD_W-1:0] radius;
	logic [WW-1:0]    width;
	logic [HW-1:0]    height;

	// sequencer to frame store
	mem_cmd_t         mem_cmd;
	logic [AW-1:0]    mem_addr;
	logic [PIX_W-1:0] mem_wdata;
	logic [PIX_W-1:0] mem_rdata;

	// result handoff into the output register
	logic    res_valid;
	logic    res_take;
	result_t res;
	result_t out_q;
	logic    out_valid_q;

	arsb_cfg_regs #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_RADIUS(MAX_RADIUS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.paint    (paint),
		.opacity  (opacity),
		.radius   (radius),
		.width    (width),
		.height   (height)
	);

	arsb_walker #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.write_pixel(write_pixel),
		.radius     (radius),
		.width      (width),
		.height     (height),
		.mem_cmd    (mem_cmd),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata),
		.mem_rdata  (mem_rdata),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res)
	);

	arsb_pixel_path #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_pixel (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mem_cmd),
		.addr   (mem_addr),
		.wdata  (mem_wdata),
		.paint  (paint),
		.opacity(opacity),
		.rdata  (mem_rdata)
	);

	// output register: loads when empty or when its content leaves this cycle
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_pixel     = out_q.pixel;
	assign off_canvas     = out_q.off;
	assign pixels_written = out_q.count;

endmodule

>>> sv/arsb_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the stamp blend unit, bound to the top level.
// Depends on arsb_pkg and alpha_rect_stamp_blend_unit.
module arsb_checker import arsb_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [PIX_W-1:0] read_pixel,
	input logic             off_canvas,
	input logic [CNT_W-1:0] pixels_written
);

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// one item at a time: busy right after a transfer in
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while busy");

	a_off_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && off_canvas |-> pixels_written == '0 && read_pixel == '0)
		else $error("off-canvas result reports data");

	a_read_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_pixel != '0 |-> pixels_written == '0)
		else $error("read result also counts writes");

endmodule

bind alpha_rect_stamp_blend_unit arsb_checker u_arsb_checker (.*);
